// File: src/quaternion_alu_core_assert.svh
// Assertion macros for the quaternion ALU core.
// Used by quaternion_alu_core.sv; expects aclk and aresetn in scope.
`ifndef QUATERNION_ALU_CORE_ASSERT_SVH
`define QUATERNION_ALU_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define QALU_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (c)) \
        else $error("qalu: implication check failed");
`define QALU_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (c)) \
        else $error("qalu: next-cycle check failed");
`else
`define QALU_ASSERT_IMP(lbl, a, c)
`define QALU_ASSERT_NXT(lbl, a, c)
`endif
`endif

// File: src/qalu_pkg.sv
// Types, constants and step functions of the quaternion ALU core.
// No dependencies; imported by quaternion_alu_core.
`timescale 1ns / 1ps
package qalu_pkg;

    localparam int DW   = 32;          // data width of every input and output word
    localparam int FB   = 16;          // fraction bits
    localparam int KW   = 4;           // operation code width
    localparam int PW   = 2 * DW;      // product width
    localparam int SUMW = PW + 2;      // exact sum of four products
    localparam int VW   = SUMW - FB;   // pre-saturation value width
    localparam int NUMW = DW + FB;     // dividend magnitude width
    localparam int DENW = VW;          // divisor magnitude width
    localparam int QW   = NUMW;        // quotient width, one bit per stage
    localparam int SQW  = PW / 2;      // root width, one bit per stage
    localparam int SRW  = SQW + 2;     // root remainder width

    localparam logic [KW-1:0] K_ADD   = KW'(0);
    localparam logic [KW-1:0] K_SUB   = KW'(1);
    localparam logic [KW-1:0] K_MUL   = KW'(2);
    localparam logic [KW-1:0] K_SCALE = KW'(3);
    localparam logic [KW-1:0] K_DIV   = KW'(4);
    localparam logic [KW-1:0] K_CONJ  = KW'(5);
    localparam logic [KW-1:0] K_INV   = KW'(6);
    localparam logic [KW-1:0] K_DOT   = KW'(7);
    localparam logic [KW-1:0] K_NSQ   = KW'(8);
    localparam logic [KW-1:0] K_NORM  = KW'(9);
    localparam logic [KW-1:0] K_CMP   = KW'(10);

    typedef logic signed [DW-1:0] word_t;
    typedef logic signed [VW-1:0] val_t;

    typedef struct packed {
        logic [KW-1:0] kind;
        val_t [3:0]    r;
        val_t          sc;
        logic          eq;
        logic          err;
    } pre_t;

    typedef struct packed {
        logic [DENW-1:0] rem;
        logic [NUMW-1:0] dvd;
        logic [QW-1:0]   quo;
        logic            neg;
    } dlane_t;

    typedef struct packed {
        pre_t            pre;
        dlane_t [3:0]    ln;
        logic [DENW-1:0] den;
        logic [PW-1:0]   rad;
        logic [SRW-1:0]  srem;
        logic [SQW-1:0]  root;
    } dstage_t;

    localparam word_t W_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam word_t W_MIN = {1'b1, {(DW-1){1'b0}}};

    function automatic word_t sat_word(val_t v);
        if ((&v[VW-1:DW-1]) || !(|v[VW-1:DW-1])) begin
            return v[DW-1:0];
        end
        return v[VW-1] ? W_MIN : W_MAX;
    endfunction

    function automatic word_t quo_word(logic neg, logic [QW-1:0] q);
        word_t m;
        m = q[DW-1:0];
        if (!neg) begin
            return (|q[QW-1:DW-1]) ? W_MAX : m;
        end
        if ((|q[QW-1:DW]) || (q[DW-1] && (|q[DW-2:0]))) begin
            return W_MIN;
        end
        return -m;
    endfunction

    // one restoring division step, one quotient bit
    function automatic dlane_t div_step(dlane_t l, logic [DENW-1:0] den);
        logic [DENW:0] t;
        dlane_t        o;
        t     = {l.rem, l.dvd[NUMW-1]};
        o     = l;
        o.dvd = l.dvd << 1;
        if (t >= {1'b0, den}) begin
            o.rem = DENW'(t - {1'b0, den});
            o.quo = {l.quo[QW-2:0], 1'b1};
        end else begin
            o.rem = t[DENW-1:0];
            o.quo = {l.quo[QW-2:0], 1'b0};
        end
        return o;
    endfunction

    // one digit-by-digit square root step, one root bit
    function automatic dstage_t sqrt_step(dstage_t s);
        logic [SRW+1:0] t;
        logic [SRW+1:0] tr;
        dstage_t        o;
        t     = {s.srem, s.rad[PW-1:PW-2]};
        tr    = {2'b00, s.root, 2'b01};
        o     = s;
        o.rad = s.rad << 2;
        if (t >= tr) begin
            o.srem = SRW'(t - tr);
            o.root = {s.root[SQW-2:0], 1'b1};
        end else begin
            o.srem = t[SRW-1:0];
            o.root = {s.root[SQW-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// File: src/quaternion_alu_core.sv
// Quaternion ALU core in signed Q16.16: add, sub, Hamilton product, scale,
// divide by scalar, conjugate, inverse, dot, squared norm, norm, compare.
// Takes one transfer per cycle while the output is not held. The pipeline
// is the 48-step bit-per-stage divider (the 32-step root runs alongside
// it), five front stages (input, multiply, two adder levels, operand prep)
// and the output register.
// A held output stalls the whole pipeline; nothing is dropped.
// Depends on qalu_pkg and quaternion_alu_core_assert.svh.
`timescale 1ns / 1ps
`include "quaternion_alu_core_assert.svh"

module quaternion_alu_core
    import qalu_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar_in (32 bits each)
    input  logic [9*DW-1:0] s_tdata,
    // kind
    input  logic [KW-1:0]  s_tuser,
    output logic           m_tvalid,
    input  logic           m_tready,
    // r_w, r_x, r_y, r_z, scalar_out (32 bits each), equal, zero pad
    output logic [167:0]   m_tdata,
    // error
    output logic [0:0]     m_tuser
);

    localparam logic [3:0] MUL_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

    logic ce;
    logic m_tvalid_reg;
    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    // stage 0: input register
    logic          v0_reg;
    logic [KW-1:0] kind0_reg;
    word_t         a0_reg [4];
    word_t         b0_reg [4];
    word_t         s0_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            kind0_reg <= s_tuser;
            for (int i = 0; i < 4; i++) begin
                a0_reg[i] <= s_tdata[i*DW +: DW];
                b0_reg[i] <= s_tdata[(i+4)*DW +: DW];
            end
            s0_reg <= s_tdata[8*DW +: DW];
        end
    end

    // stage 1: products, plus add/sub/conj/compare
    logic                 v1_reg;
    logic signed [PW-1:0] p1_next [4][4];
    logic signed [PW-1:0] p1_reg  [4][4];
    word_t                mx [4][4];
    word_t                my [4][4];
    logic                 mn [4][4];
    pre_t                 pre1_next, pre1_reg;
    word_t                a1_reg [4];
    word_t                s1_reg;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int t = 0; t < 4; t++) begin
                mx[r][t] = '0;
                my[r][t] = '0;
                mn[r][t] = 1'b0;
                unique case (kind0_reg)
                    K_MUL: begin
                        mx[r][t] = a0_reg[t];
                        my[r][t] = b0_reg[2'(r ^ t)];
                        mn[r][t] = MUL_NEG[r][t];
                    end
                    K_DOT: begin
                        if (r == 0) begin
                            mx[r][t] = a0_reg[t];
                            my[r][t] = b0_reg[t];
                        end
                    end
                    K_INV, K_NSQ, K_NORM: begin
                        if (r == 0) begin
                            mx[r][t] = a0_reg[t];
                            my[r][t] = a0_reg[t];
                        end
                    end
                    K_SCALE: begin
                        if (t == 0) begin
                            mx[r][t] = a0_reg[r];
                            my[r][t] = s0_reg;
                        end
                    end
                    default: ;
                endcase
                p1_next[r][t] = mx[r][t] * my[r][t];
                if (mn[r][t]) p1_next[r][t] = -p1_next[r][t];
            end
        end
    end

    always_comb begin
        pre1_next      = '0;
        pre1_next.kind = kind0_reg;
        for (int i = 0; i < 4; i++) begin
            unique case (kind0_reg)
                K_ADD:   pre1_next.r[i] = VW'(a0_reg[i]) + VW'(b0_reg[i]);
                K_SUB:   pre1_next.r[i] = VW'(a0_reg[i]) - VW'(b0_reg[i]);
                K_CONJ:  pre1_next.r[i] = (i == 0) ? VW'(a0_reg[i]) : -VW'(a0_reg[i]);
                default: pre1_next.r[i] = '0;
            endcase
        end
        pre1_next.eq = (kind0_reg == K_CMP) &&
                       (a0_reg[0] == b0_reg[0]) && (a0_reg[1] == b0_reg[1]) &&
                       (a0_reg[2] == b0_reg[2]) && (a0_reg[3] == b0_reg[3]);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p1_reg   <= p1_next;
            pre1_reg <= pre1_next;
            a1_reg   <= a0_reg;
            s1_reg   <= s0_reg;
        end
    end

    // stage 2: pair sums
    logic               v2_reg;
    logic signed [PW:0] p2_reg [4][2];
    pre_t               pre2_reg;
    word_t              a2_reg [4];
    word_t              s2_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int r = 0; r < 4; r++) begin
                for (int j = 0; j < 2; j++) begin
                    p2_reg[r][j] <= (PW+1)'(p1_reg[r][2*j]) + (PW+1)'(p1_reg[r][2*j+1]);
                end
            end
            pre2_reg <= pre1_reg;
            a2_reg   <= a1_reg;
            s2_reg   <= s1_reg;
        end
    end

    // stage 3: exact row sums
    logic                   v3_reg;
    logic signed [SUMW-1:0] s3_reg [4];
    pre_t                   pre3_reg;
    word_t                  a3_reg [4];
    word_t                  sc3_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int r = 0; r < 4; r++) begin
                s3_reg[r] <= SUMW'(p2_reg[r][0]) + SUMW'(p2_reg[r][1]);
            end
            pre3_reg <= pre2_reg;
            a3_reg   <= a2_reg;
            sc3_reg  <= s2_reg;
        end
    end

    // stage 4: floor shift, divider and root operands
    dstage_t         st_reg [QW+1];
    dstage_t         st0_next;
    logic [QW:0]     sv_reg;
    val_t            fs [4];
    logic [DW-1:0]   amag [4];
    logic [DW-1:0]   smag;
    logic            inv_op;

    always_comb begin
        st0_next     = '0;
        st0_next.pre = pre3_reg;
        inv_op       = (pre3_reg.kind == K_INV);
        for (int r = 0; r < 4; r++) begin
            fs[r]   = s3_reg[r][SUMW-1:FB];
            amag[r] = a3_reg[r][DW-1] ? DW'(-a3_reg[r]) : a3_reg[r];
            st0_next.ln[r].dvd = {amag[r], {FB{1'b0}}};
            st0_next.ln[r].neg = a3_reg[r][DW-1] ^ (inv_op && (r != 0)) ^
                                 (!inv_op && sc3_reg[DW-1]);
        end
        // unsigned magnitude, so the most negative scalar widens to +2^31
        smag         = sc3_reg[DW-1] ? DW'(-sc3_reg) : sc3_reg;
        st0_next.den = inv_op ? DENW'(fs[0]) : DENW'(smag);
        unique case (pre3_reg.kind)
            K_MUL, K_SCALE: begin
                for (int r = 0; r < 4; r++) st0_next.pre.r[r] = fs[r];
            end
            K_DOT, K_NSQ: st0_next.pre.sc  = fs[0];
            K_DIV:        st0_next.pre.err = (sc3_reg == '0);
            K_INV:        st0_next.pre.err = (fs[0] == '0);
            default: ;
        endcase
        // squared-norm sum saturates at all ones before the root
        st0_next.rad = (|s3_reg[0][SUMW-1:PW]) ? {PW{1'b1}} : s3_reg[0][PW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ce) st_reg[0] <= st0_next;
    end

    // stages 5 and up: one quotient bit per stage, plus one root bit in the first SQW stages
    for (genvar k = 0; k < QW; k++) begin : g_step
        dstage_t st_next;
        always_comb begin
            st_next = st_reg[k];
            if (k < SQW) st_next = sqrt_step(st_reg[k]);
            for (int i = 0; i < 4; i++) begin
                st_next.ln[i] = div_step(st_reg[k].ln[i], st_reg[k].den);
            end
        end
        always_ff @(posedge aclk) begin
            if (ce) st_reg[k+1] <= st_next;
        end
    end

    // output register
    dstage_t fin;
    word_t   rq_next [4];
    word_t   sc_next;
    logic    use_quo;

    always_comb begin
        fin     = st_reg[QW];
        use_quo = ((fin.pre.kind == K_DIV) || (fin.pre.kind == K_INV)) && !fin.pre.err;
        for (int i = 0; i < 4; i++) begin
            rq_next[i] = use_quo ? quo_word(fin.ln[i].neg, fin.ln[i].quo)
                                 : sat_word(fin.pre.r[i]);
        end
        if (fin.pre.kind == K_NORM) begin
            sc_next = (|fin.root[SQW-1:DW-1]) ? W_MAX : DW'(fin.root);
        end else begin
            sc_next = sat_word(fin.pre.sc);
        end
    end

    logic [167:0] m_tdata_reg;
    logic         m_err_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= {7'd0, fin.pre.eq, sc_next,
                            rq_next[3], rq_next[2], rq_next[1], rq_next[0]};
            m_err_reg   <= fin.pre.err;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            sv_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            v0_reg       <= s_tvalid;
            v1_reg       <= v0_reg;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            sv_reg       <= {sv_reg[QW-1:0], v3_reg};
            m_tvalid_reg <= sv_reg[QW];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_err_reg;

    `QALU_ASSERT_IMP(a_err_zero, m_tvalid && m_tuser[0], (m_tdata[160:0] == '0))
    `QALU_ASSERT_IMP(a_eq_clean, m_tvalid && m_tdata[160], (m_tdata[159:0] == '0) && !m_tuser[0])
    `QALU_ASSERT_NXT(a_enter, ce && s_tvalid, v0_reg)

endmodule

// File: tb/quaternion_alu_core_test.sv
// Testbench for quaternion_alu_core: directed table then random traffic,
// results checked against an in-bench Q16.16 predictor. Depends on qalu_pkg.
`timescale 1ns / 1ps

module quaternion_alu_core_test;
    import qalu_pkg::*;

    typedef struct {
        logic [KW-1:0]       kind;
        logic signed [31:0]  a [4];
        logic signed [31:0]  b [4];
        logic signed [31:0]  s;
    } op_t;

    typedef struct {
        logic signed [31:0] r [4];
        logic signed [31:0] sc;
        logic               eq;
        logic               err;
    } res_t;

    typedef struct {
        op_t  op;
        bit   fixed;
        res_t res;
    } row_t;

    localparam int STALL_LIMIT = 5000;
    localparam int PIPE_DEPTH  = 53;
    localparam logic [KW-1:0] K_BAD = KW'(13);

    logic            aclk = 0;
    logic            aresetn = 0;
    logic            s_tvalid = 0;
    logic            s_tready;
    logic [9*DW-1:0] s_tdata = '0;
    logic [KW-1:0]   s_tuser = '0;
    logic            m_tvalid;
    logic            m_tready = 0;
    logic [167:0]    m_tdata;
    logic [0:0]      m_tuser;

    res_t  results_due [$];
    int    errors = 0;
    int    checked = 0;
    int    sent = 0;
    int    idle_cycles = 0;
    bit    stim_done = 0;
    int    kind_seen [16];

    always #10 aclk = ~aclk;

    quaternion_alu_core uut (.*);

    function automatic logic signed [31:0] sat(logic signed [127:0] v);
        if (v > 128'sh7fffffff) return 32'sh7fffffff;
        if (v < -128'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    // arithmetic shift is floor for the signed sum
    function automatic logic signed [127:0] fsh(logic signed [127:0] p);
        return p >>> 16;
    endfunction

    function automatic logic signed [127:0] qdiv(logic signed [127:0] n,
                                                  logic signed [127:0] d);
        return (n <<< 16) / d;  // SV division truncates toward zero
    endfunction

    function automatic logic [63:0] root64(logic [127:0] n);
        logic [127:0] lo, hi, mid;
        lo = 0;
        hi = 128'h1_0000_0000_0000_0000;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= n) lo = mid; else hi = mid;
        end
        return lo[63:0];
    endfunction

    function automatic res_t predict_alu(op_t o);
        logic signed [127:0] a [4], b [4], s, r [4], sc, n;
        logic [127:0] acc;
        res_t x;
        for (int i = 0; i < 4; i++) begin
            a[i] = o.a[i];
            b[i] = o.b[i];
            r[i] = 0;
        end
        s = o.s;
        sc = 0;
        x.eq = 0;
        x.err = 0;
        case (o.kind)
            K_ADD: for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
            K_SUB: for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
            K_MUL: begin
                r[0] = fsh(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]);
                r[1] = fsh(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]);
                r[2] = fsh(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]);
                r[3] = fsh(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]);
            end
            K_SCALE: for (int i = 0; i < 4; i++) r[i] = fsh(a[i] * s);
            K_DIV: begin
                if (s == 0) x.err = 1;
                else for (int i = 0; i < 4; i++) r[i] = qdiv(a[i], s);
            end
            K_CONJ: begin
                r[0] = a[0];
                for (int i = 1; i < 4; i++) r[i] = -a[i];
            end
            K_INV: begin
                n = fsh(a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3]);
                if (n == 0) x.err = 1;
                else begin
                    r[0] = qdiv(a[0], n);
                    for (int i = 1; i < 4; i++) r[i] = qdiv(-a[i], n);
                end
            end
            K_DOT:  sc = fsh(a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3]);
            K_NSQ:  sc = fsh(a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3]);
            K_NORM: begin
                acc = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
                if (acc > 128'hffff_ffff_ffff_ffff) acc = 128'hffff_ffff_ffff_ffff;
                sc = {64'd0, root64(acc)};
            end
            K_CMP: x.eq = (a[0] == b[0]) && (a[1] == b[1]) &&
                          (a[2] == b[2]) && (a[3] == b[3]);
            default: ;
        endcase
        for (int i = 0; i < 4; i++) x.r[i] = sat(r[i]);
        x.sc = sat(sc);
        return x;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch #%0d %s: got %h want %h", checked, what, got, want);
        errors++;
    endtask

    // random Q16.16 word: mostly moderate, sometimes full range or extremes
    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return ($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000);
            2: return $signed($urandom_range(0, 8)) - 4;
            3, 4: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
            default: return $signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
        endcase
    endfunction

    function automatic op_t rand_op();
        op_t o;
        o.kind = ($urandom_range(0, 19) == 0) ? KW'($urandom_range(11, 15))
                                              : KW'($urandom_range(0, 10));
        for (int i = 0; i < 4; i++) begin
            o.a[i] = rand_word();
            o.b[i] = rand_word();
        end
        o.s = ($urandom_range(0, 15) == 0) ? 32'sd0 : rand_word();
        if (o.kind == K_CMP && $urandom_range(0, 1)) begin
            o.b = o.a;
            if ($urandom_range(0, 1)) o.b[$urandom_range(0, 3)] ^= 32'h1 << $urandom_range(0, 31);
        end
        if (o.kind == K_INV && $urandom_range(0, 4) == 0)
            for (int i = 0; i < 4; i++) o.a[i] = $signed($urandom_range(0, 200)) - 100;
        return o;
    endfunction

    function automatic op_t mk(logic [KW-1:0] k, logic signed [31:0] av,
                               logic signed [31:0] bv, logic signed [31:0] sv);
        op_t o;
        o.kind = k;
        for (int i = 0; i < 4; i++) begin
            o.a[i] = av + i;
            o.b[i] = bv - i;
        end
        o.s = sv;
        return o;
    endfunction

    function automatic res_t zeros(logic err);
        res_t x;
        for (int i = 0; i < 4; i++) x.r[i] = 0;
        x.sc = 0;
        x.eq = 0;
        x.err = err;
        return x;
    endfunction

    task automatic send(op_t o);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                          : ($urandom_range(0, 2) == 0 ? 1 : 0);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= o.kind;
        s_tdata  <= {o.s, o.b[3], o.b[2], o.b[1], o.b[0], o.a[3], o.a[2], o.a[1], o.a[0]};
        do @(posedge aclk); while (!s_tready);
        sent++;
        kind_seen[o.kind]++;
    endtask

    task automatic push_due(op_t o);
        results_due.push_back(predict_alu(o));
    endtask

    // expectation is queued right after the transfer edge, long before its result
    task automatic drive(op_t o, bit fx, res_t fr);
        send(o);
        if (fx) results_due.push_back(fr);
        else push_due(o);
    endtask

    // result side: random stalls and checking
    always @(posedge aclk) begin
        res_t w;
        logic [31:0] g [5];
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                for (int i = 0; i < 5; i++) g[i] = m_tdata[32*i +: 32];
                if (results_due.size() == 0) begin
                    $display("unexpected result transfer");
                    errors++;
                end else begin
                    w = results_due.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (g[i] !== w.r[i]) report_mismatch($sformatf("r[%0d]", i), g[i], w.r[i]);
                    if (g[4] !== w.sc) report_mismatch("scalar_out", g[4], w.sc);
                    if (m_tdata[160] !== w.eq) report_mismatch("equal", m_tdata[160], w.eq);
                    if (m_tuser[0] !== w.err) report_mismatch("error", m_tuser[0], w.err);
                end
                checked++;
            end
            if (($urandom_range(0, 1) && sent > 600 && sent < 700))
                m_tready <= 1;
            else if ($urandom_range(0, 29) == 0)
                m_tready <= 0;
            else if ($urandom_range(0, 3) == 0)
                m_tready <= ~m_tready;
            else
                m_tready <= 1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("timeout: %0d results still due", results_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    row_t dir [$];

    initial begin
        row_t rw;
        res_t z;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        z = zeros(0);
        // after reset, trivial rows with typed results
        rw.op = mk(K_ADD, 0, 0, 0); rw.op.a = '{0, 0, 0, 0}; rw.op.b = '{0, 0, 0, 0};
        rw.fixed = 1; rw.res = z; dir.push_back(rw);
        rw.op = mk(K_DIV, 32'sh10000, 5, 0);
        rw.res = zeros(1); dir.push_back(rw);
        rw.op = mk(K_INV, 0, 0, 0); rw.op.a = '{0, 0, 0, 0};
        rw.res = zeros(1); dir.push_back(rw);
        rw.op = mk(K_INV, 1, 0, 0); rw.op.a = '{1, -1, 2, 0};  // tiny norm
        rw.res = zeros(1); dir.push_back(rw);
        rw.op = mk(K_BAD, 32'sh7fffffff, -1, 7);
        rw.res = z; dir.push_back(rw);
        rw.op = mk(K_ADD, 32'sh7ffffff0, 32'sh7ffffff0, 0);
        rw.res = z; for (int i = 0; i < 4; i++) rw.res.r[i] = 32'sh7fffffff;
        dir.push_back(rw);
        rw.op = mk(K_SUB, 32'sh80000000, 32'sh7fffffff, 0);
        rw.res = z; rw.res.r[0] = 32'sh80000000; rw.res.r[1] = 32'sh80000000;
        rw.res.r[2] = 32'sh80000000; rw.res.r[3] = 32'sh80000000; dir.push_back(rw);
        rw.op = mk(K_CMP, 5, 0, 0); rw.op.b = rw.op.a;
        rw.res = z; rw.res.eq = 1; dir.push_back(rw);
        // remaining rows go to the predictor
        rw.fixed = 0;
        rw.op = mk(K_MUL, 32'sh10000, 32'sh20000, 0); dir.push_back(rw);
        rw.op = mk(K_MUL, 32'sh80000000, 32'sh80000000, 0); dir.push_back(rw);
        rw.op = mk(K_SCALE, 32'sh7fffffff, 0, 32'sh80000000); dir.push_back(rw);
        rw.op = mk(K_SCALE, -32'sh18000, 0, 32'sh8000); dir.push_back(rw);
        rw.op = mk(K_DIV, 32'sh80000000, 0, -1); dir.push_back(rw);
        rw.op = mk(K_DIV, -32'sh30000, 0, 32'sh20000); dir.push_back(rw);
        rw.op = mk(K_DIV, 32'sh7fffffff, 0, 32'sh80000000); dir.push_back(rw);
        rw.op = mk(K_CONJ, 32'sh80000000, 0, 0); dir.push_back(rw);
        rw.op = mk(K_INV, 32'sh10000, 0, 0); dir.push_back(rw);
        rw.op = mk(K_INV, 32'sh7fffffff, 0, 0); dir.push_back(rw);
        rw.op = mk(K_INV, 32'sh100, 0, 0); dir.push_back(rw);
        rw.op = mk(K_DOT, 32'sh80000000, 32'sh80000000, 0); dir.push_back(rw);
        rw.op = mk(K_DOT, -32'sh10001, 32'sh3, 0); dir.push_back(rw);
        rw.op = mk(K_NSQ, 32'sh7fffffff, 0, 0); dir.push_back(rw);
        rw.op = mk(K_NORM, 32'sh80000000, 0, 0); dir.push_back(rw);
        rw.op = mk(K_NORM, 32'sh30000, 0, 0); dir.push_back(rw);
        rw.op = mk(K_CMP, 5, 5, 0); dir.push_back(rw);
        rw.op = mk(4'd15, -1, -1, -1); dir.push_back(rw);

        foreach (dir[i]) drive(dir[i].op, dir[i].fixed, dir[i].res);

        for (int n = 0; n < 1300; n++) begin
            if (n == 650) begin
                // drain the pipeline before resuming
                s_tvalid <= 0;
                while (results_due.size() != 0) @(posedge aclk);
            end
            drive(rand_op(), 0, z);
        end
        s_tvalid <= 0;
        stim_done = 1;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 10) @(posedge aclk);

        $display("covered %0d operations, %0d results checked", sent, checked);
        $display("kinds: add %0d mul %0d div %0d inv %0d norm %0d cmp %0d other %0d",
                 kind_seen[K_ADD], kind_seen[K_MUL], kind_seen[K_DIV], kind_seen[K_INV],
                 kind_seen[K_NORM], kind_seen[K_CMP],
                 kind_seen[11] + kind_seen[12] + kind_seen[13] + kind_seen[14] + kind_seen[15]);
        if (errors == 0 && results_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
